[src/cdd_pkg.sv]
// Shared types, register indexes, reset values and codes for the crash deploy decision block.
// No dependencies; cdd_eval, the top level and the testbench import this package.
package cdd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STUCK_LIMIT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ARMING_LEVEL  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_V_LEVEL = 2'd3;

  localparam logic [14:0]        RANGE_LIMIT_RESET   = 15'd30000;
  localparam logic [15:0]        STUCK_LIMIT_RESET   = 16'd100;
  localparam logic signed [15:0] ARMING_LEVEL_RESET  = -16'sd4096;
  localparam logic signed [31:0] DELTA_V_LEVEL_RESET = -32'sd100000;

  // leak factor 58982/65536, about 0.9
  localparam logic [15:0] LEAK_NUM   = 16'd58982;
  localparam int          LEAK_SHIFT = 16;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_FAULT    = 2'd1,
    MODE_DEPLOYED = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CODE_CLEAR = 2'd0,
    CODE_RANGE = 2'd1,
    CODE_STUCK = 2'd2
  } error_t;

  typedef struct packed {
    logic [14:0]        range_limit;
    logic [15:0]        stuck_limit;
    logic signed [15:0] arming_level;
    logic signed [31:0] delta_v_level;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] velocity_sum;
    logic signed [15:0] previous_x;
    logic [15:0]        same_count;
    mode_t              mode_reg;
    error_t             error_reg;
    logic               fired;
  } state_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] filtered_accel_x;
  } sample_t;

  typedef struct packed {
    logic [1:0] unit_state;
    logic [1:0] error_code;
    logic       fire;
    logic       fault_now;
  } result_t;

endpackage

[src/cdd_stream_if.sv]
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is a parameter; no package dependency.
interface cdd_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/cdd_eval.sv]
// Single-pass evaluation of one sample: fault checks, delta-v update, deploy test.
// Depends on cdd_pkg.
module cdd_eval (
  input  cdd_pkg::cfg_t    cfg,
  input  cdd_pkg::state_t  state,
  input  cdd_pkg::sample_t sample,
  output cdd_pkg::state_t  state_next,
  output cdd_pkg::result_t result
);
  import cdd_pkg::*;

  logic [16:0]        mag_x, mag_y, mag_z, mag_arm, lim;
  logic               out_of_range, x_same, stuck, fault, armed, deploy;
  logic [15:0]        count_inc;
  logic signed [32:0] sum_add;
  logic signed [31:0] sum_neg;
  logic signed [48:0] prod;
  logic signed [32:0] prod_floor;
  logic signed [31:0] sum_leak;
  logic signed [31:0] sum_new;

  function automatic logic [16:0] abs16(input logic signed [15:0] a);
    logic signed [16:0] w;
    w = {a[15], a};
    return w[16] ? 17'(-w) : 17'(w);
  endfunction

  always_comb begin
    mag_x   = abs16(sample.accel_x);
    mag_y   = abs16(sample.accel_y);
    mag_z   = abs16(sample.accel_z);
    mag_arm = abs16(cfg.arming_level);
    lim     = {2'b00, cfg.range_limit};

    out_of_range = (mag_x > lim) || (mag_y > lim) || (mag_z > lim);
    x_same       = (sample.accel_x == state.previous_x);
    count_inc    = (state.same_count == COUNT_MAX) ? state.same_count
                                                   : state.same_count + 16'd1;
    stuck        = !out_of_range && x_same && (count_inc >= cfg.stuck_limit);
    fault        = out_of_range || stuck;

    sum_add = {state.velocity_sum[31], state.velocity_sum}
            + {{17{sample.filtered_accel_x[15]}}, sample.filtered_accel_x};
    sum_neg = (sum_add[32] != sum_add[31]) ? {1'b1, 31'd0} : sum_add[31:0];

    // leak with truncation toward zero
    prod       = {{17{state.velocity_sum[31]}}, state.velocity_sum}
               * $signed({33'd0, LEAK_NUM});
    prod_floor = prod[48:LEAK_SHIFT];
    if (prod[48] && (prod[LEAK_SHIFT-1:0] != '0)) begin
      prod_floor = prod_floor + 33'sd1;
    end
    sum_leak = prod_floor[31:0];

    sum_new = sample.filtered_accel_x[15] ? sum_neg : sum_leak;

    armed  = (sample.filtered_accel_x < cfg.arming_level) || (mag_y > mag_arm);
    deploy = !fault && (sum_new <= cfg.delta_v_level) && armed;

    state_next = state;
    priority if (out_of_range) begin
      state_next.mode_reg  = MODE_FAULT;
      state_next.error_reg = CODE_RANGE;
    end else if (x_same) begin
      state_next.same_count = count_inc;
      if (stuck) begin
        state_next.mode_reg  = MODE_FAULT;
        state_next.error_reg = CODE_STUCK;
      end
    end else begin
      state_next.same_count = '0;
    end

    if (!fault) begin
      state_next.previous_x   = sample.accel_x;
      state_next.velocity_sum = sum_new;
      if (deploy) begin
        state_next.mode_reg = MODE_DEPLOYED;
        state_next.fired    = 1'b1;
      end
    end

    result.unit_state = state_next.mode_reg;
    result.error_code = state_next.error_reg;
    result.fire       = state_next.fired;
    result.fault_now  = fault;
  end

endmodule

[src/crash_deploy_decision.sv]
// Crash deploy decision top level: input register, evaluation, result register.
// Depends on cdd_pkg, cdd_stream_if and cdd_eval.
// Path: input register, then cdd_eval, then result register.
// Throughput: one sample per cycle unless results stall; state feeds back through cdd_eval.
// Reset: synchronous rst restores register defaults, clears state and both valid flags.
module crash_deploy_decision (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [cdd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [cdd_pkg::CFG_DATA_W-1:0]        cfg_data,
  cdd_stream_if.sink                            sample,
  cdd_stream_if.source                          result
);
  import cdd_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  sample_t in_data;
  logic    in_valid;
  result_t out_data;
  result_t out_next;
  logic    out_valid;
  logic    advance;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !rst && (!in_valid || advance);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  cdd_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .sample     (in_data),
    .state_next (state_next),
    .result     (out_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_limit   <= RANGE_LIMIT_RESET;
      cfg.stuck_limit   <= STUCK_LIMIT_RESET;
      cfg.arming_level  <= ARMING_LEVEL_RESET;
      cfg.delta_v_level <= DELTA_V_LEVEL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANGE_LIMIT:   cfg.range_limit   <= cfg_data[14:0];
        REG_STUCK_LIMIT:   cfg.stuck_limit   <= cfg_data[15:0];
        REG_ARMING_LEVEL:  cfg.arming_level  <= cfg_data[15:0];
        REG_DELTA_V_LEVEL: cfg.delta_v_level <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.velocity_sum <= '0;
      state.previous_x   <= '0;
      state.same_count   <= '0;
      state.mode_reg     <= MODE_NORMAL;
      state.error_reg    <= CODE_CLEAR;
      state.fired        <= 1'b0;
      in_valid           <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (sample.ready) begin
        in_valid <= sample.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_data <= sample.data;
    end
    if (advance) begin
      out_data <= out_next;
    end
  end

endmodule

[sim/tb_crash_deploy_decision.sv]
// Self-checking testbench for crash_deploy_decision: directed table, then random phases.
// Depends on cdd_pkg, cdd_stream_if and the crash_deploy_decision top level.
// Results are checked against a cycle-free predictor of the decision logic or, for typed rows, the table.
module tb_crash_deploy_decision;
  import cdd_pkg::*;

  localparam int     STALL_LIMIT     = 4000;
  localparam int     NUM_PHASES      = 6;
  localparam int     ITEMS_PER_PHASE = 140;
  localparam longint VSUM_MIN        = -(64'sd1 <<< 31);

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
    sample_t                sample;
    logic [16:0]            reps;
    logic                   typed;
    result_t                want;
  } stim_row_t;

  localparam sample_t NO_SAMPLE = '0;
  localparam result_t NO_RESULT = '0;
  localparam result_t RANGE_FAULT = '{MODE_FAULT, CODE_RANGE, 1'b0, 1'b1};

  localparam stim_row_t DIRECTED [22] = '{
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 17'd1, 1'b1,
      '{MODE_NORMAL, CODE_CLEAR, 1'b0, 1'b0}},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 17'd1,
      1'b1, RANGE_FAULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd0, 16'sh8000, 16'sd0, 16'sd0}, 17'd1,
      1'b1, RANGE_FAULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd0, 16'sd0, 16'sd30001, 16'sd0}, 17'd1,
      1'b1, RANGE_FAULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd1, 16'sd30000, -16'sd30000, 16'sd0}, 17'd1,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd2, 16'sd0, 16'sd0, 16'sh8000}, 17'd5,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd3, 16'sd0, 16'sd0, 16'sd32767}, 17'd3,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd4, 16'sd4097, 16'sd0, -16'sd1}, 17'd1,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd5, -16'sd4096, 16'sd0, -16'sd4096}, 17'd1,
      1'b0, NO_RESULT},
    '{ROW_CONFIG, REG_RANGE_LIMIT, 32'd32767, NO_SAMPLE, 17'd0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 17'd1,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0,
      '{16'sd32767, -16'sd32767, 16'sd32767, -16'sd32767}, 17'd1, 1'b0, NO_RESULT},
    '{ROW_CONFIG, REG_STUCK_LIMIT, 32'd65535, NO_SAMPLE, 17'd0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd99, 16'sd0, 16'sd0, 16'sh8000}, 17'd4,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd100, 16'sd0, 16'sd0, 16'sh8000}, 17'd6,
      1'b0, NO_RESULT},
    '{ROW_CONFIG, REG_STUCK_LIMIT, 32'd0, NO_SAMPLE, 17'd0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd7, 16'sd0, 16'sd0, 16'sd0}, 17'd2,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd8, 16'sd0, 16'sd0, 16'sd5}, 17'd1,
      1'b0, NO_RESULT},
    '{ROW_CONFIG, REG_ARMING_LEVEL, 32'h0000_0100, NO_SAMPLE, 17'd0, 1'b0, NO_RESULT},
    '{ROW_CONFIG, REG_DELTA_V_LEVEL, 32'h0000_1000, NO_SAMPLE, 17'd0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd9, 16'sd0, 16'sd0, 16'sd100}, 17'd1,
      1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_RANGE_LIMIT, 32'd0, '{16'sd10, -16'sd300, 16'sd0, 16'sd300}, 17'd1,
      1'b0, NO_RESULT}
  };

  localparam cfg_t PHASE_CFG [NUM_PHASES] = '{
    '{RANGE_LIMIT_RESET, STUCK_LIMIT_RESET, ARMING_LEVEL_RESET, DELTA_V_LEVEL_RESET},
    '{15'd32767, 16'd1, 16'sd0, 32'sd0},
    '{15'd0, 16'd65535, 16'sh8000, 32'sh8000_0000},
    '{15'd12000, 16'd5, -16'sd1000, -32'sd20000},
    '{15'd20000, 16'd3, 16'sh7fff, 32'sd1000},
    '{15'd30000, 16'd20, -16'sd8000, -32'sd300000}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cdd_stream_if #(.data_t(sample_t)) sample_bus ();
  cdd_stream_if #(.data_t(result_t)) result_bus ();

  crash_deploy_decision i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_bus),
    .result    (result_bus)
  );

  cfg_t    deploy_cfg;
  state_t  deploy_state;
  result_t expected_decisions [$];
  int      mismatch_count = 0;
  int      stall_cycles = 0;
  int      send_idle_pct;
  int      recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint magnitude(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic result_t predict_decision(input sample_t s);
    longint  ax, ay, az, fx, lim, v;
    logic    fault;
    logic    armed;
    result_t r;
    ax = $signed(s.accel_x);
    ay = $signed(s.accel_y);
    az = $signed(s.accel_z);
    fx = $signed(s.filtered_accel_x);
    lim = longint'(deploy_cfg.range_limit);
    fault = 1'b0;
    if (magnitude(ax) > lim || magnitude(ay) > lim || magnitude(az) > lim) begin
      deploy_state.mode_reg  = MODE_FAULT;
      deploy_state.error_reg = CODE_RANGE;
      fault = 1'b1;
    end else if (ax == longint'($signed(deploy_state.previous_x))) begin
      if (deploy_state.same_count < COUNT_MAX) begin
        deploy_state.same_count = deploy_state.same_count + 16'd1;
      end
      if (deploy_state.same_count >= deploy_cfg.stuck_limit) begin
        deploy_state.mode_reg  = MODE_FAULT;
        deploy_state.error_reg = CODE_STUCK;
        fault = 1'b1;
      end
    end else begin
      deploy_state.same_count = '0;
    end
    if (!fault) begin
      deploy_state.previous_x = s.accel_x;
      v = $signed(deploy_state.velocity_sum);
      if (fx < 0) begin
        v = v + fx;
        if (v < VSUM_MIN) begin
          v = VSUM_MIN;
        end
      end else begin
        v = (v * longint'(LEAK_NUM)) / (64'sd1 <<< LEAK_SHIFT);
      end
      deploy_state.velocity_sum = 32'(v);
      armed = (fx < longint'(deploy_cfg.arming_level)) ||
              (magnitude(ay) > magnitude(longint'(deploy_cfg.arming_level)));
      if (longint'(deploy_state.velocity_sum) <= longint'(deploy_cfg.delta_v_level) &&
          armed) begin
        deploy_state.mode_reg = MODE_DEPLOYED;
        deploy_state.fired    = 1'b1;
      end
    end
    r.unit_state = deploy_state.mode_reg;
    r.error_code = deploy_state.error_reg;
    r.fire       = deploy_state.fired;
    r.fault_now  = fault;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_axis(input int lim);
    return 16'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  task automatic transmit_sample(input sample_t s, input logic typed, input result_t want);
    result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.data  <= s;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    pred = predict_decision(s);
    expected_decisions.push_back(typed ? want : pred);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    sample_bus.valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_RANGE_LIMIT:   deploy_cfg.range_limit   = val[14:0];
      REG_STUCK_LIMIT:   deploy_cfg.stuck_limit   = val[15:0];
      REG_ARMING_LEVEL:  deploy_cfg.arming_level  = val[15:0];
      REG_DELTA_V_LEVEL: deploy_cfg.delta_v_level = val[31:0];
      default: ;
    endcase
  endtask

  task automatic run_random_phase(input int n_items);
    int                 sent;
    int                 kind;
    int                 len;
    int                 lim;
    logic signed [15:0] hold_x;
    sample_t            s;
    sent = 0;
    lim = int'(deploy_cfg.range_limit);
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      hold_x = rand_axis(lim);
      if (kind >= 40 && kind < 60) begin
        len = (deploy_cfg.stuck_limit < 70) ? int'(deploy_cfg.stuck_limit) + $urandom_range(0, 4)
                                            : $urandom_range(10, 60);
      end else if (kind >= 90) begin
        len = $urandom_range(1, 4);
      end else begin
        len = $urandom_range(3, 30);
      end
      for (int k = 0; k < len; k++) begin
        s.accel_x = rand_axis(lim);
        s.accel_y = rand_axis(lim);
        s.accel_z = rand_axis(lim);
        s.filtered_accel_x = 16'($urandom);
        if (kind < 40) begin
          s.filtered_accel_x = 16'(-int'($urandom_range(1, 32768)));
        end else if (kind < 60) begin
          s.accel_x = hold_x;
        end else if (kind < 75) begin
          s.filtered_accel_x = 16'(int'($urandom_range(0, 1600)) - 800);
        end else if (kind < 90) begin
          s.filtered_accel_x = 16'(-int'($urandom_range(0, 8000)));
        end else begin
          s.accel_x = 16'($urandom);
          s.accel_y = 16'($urandom);
          s.accel_z = 16'($urandom);
        end
        if ($urandom_range(0, 49) == 0) begin
          s.accel_z = 16'($urandom);
        end
        transmit_sample(s, 1'b0, NO_RESULT);
        sent++;
      end
    end
  endtask

  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = result_bus.data;
      if (expected_decisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result transaction: actual %p", got);
        end
      end else begin
        want = expected_decisions.pop_front();
        if (got.unit_state !== want.unit_state || got.error_code !== want.error_code ||
            got.fire !== want.fire || got.fault_now !== want.fault_now) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected state %0d error %0d fire %0d fault %0d, %s",
                     want.unit_state, want.error_code, want.fire, want.fault_now,
                     $sformatf("actual state %0d error %0d fire %0d fault %0d",
                               got.unit_state, got.error_code, got.fire, got.fault_now));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    sample_bus.valid <= 1'b0;
    sample_bus.data  <= '0;
    deploy_cfg = '{RANGE_LIMIT_RESET, STUCK_LIMIT_RESET, ARMING_LEVEL_RESET,
                   DELTA_V_LEVEL_RESET};
    deploy_state = '0;
    send_idle_pct = 8;
    recv_idle_pct = 47;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CONFIG) begin
        write_register(DIRECTED[i].index, DIRECTED[i].value);
      end else begin
        for (int n = 0; n < int'(DIRECTED[i].reps); n++) begin
          transmit_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].want);
        end
      end
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 47;
      end else if (p < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_register(REG_RANGE_LIMIT, 32'(PHASE_CFG[p].range_limit));
      write_register(REG_STUCK_LIMIT, 32'(PHASE_CFG[p].stuck_limit));
      write_register(REG_ARMING_LEVEL, 32'(PHASE_CFG[p].arming_level));
      write_register(REG_DELTA_V_LEVEL, 32'(PHASE_CFG[p].delta_v_level));
      run_random_phase(ITEMS_PER_PHASE);
    end
    sample_bus.valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
